// ===== hdl/bgd_pkg.sv =====
`default_nettype none

package bgd_pkg;

   localparam int THRESH_BITS    = 16;
   localparam int STAMP_IN_BITS  = 32;
   localparam int CSR_INDEX_BITS = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HOLD_THRESHOLD      = 4'd0,
      CSR_LIVE_FILL_THRESHOLD = 4'd1,
      CSR_TAP_MAX             = 4'd2,
      CSR_DOUBLE_TAP_WINDOW   = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      AUX_NONE      = 2'd0,
      AUX_HAT       = 2'd1,
      AUX_FILL_GATE = 2'd2
   } aux_request_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] hold_threshold_ms;
      logic [THRESH_BITS-1:0] live_fill_threshold_ms;
      logic [THRESH_BITS-1:0] tap_max_ms;
      logic [THRESH_BITS-1:0] double_tap_window_ms;
   } cfg_type;

   typedef struct packed {
      logic                     button_pressed;
      logic                     switch_up;
      logic [STAMP_IN_BITS-1:0] time_ms;
      logic                     knob_moved;
   } sample_type;

   typedef struct packed {
      logic            tap;
      logic            double_tap;
      logic            shift_on;
      logic            live_fill_on;
      logic            switch_consumed;
      aux_request_type aux_request;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/bgd_core.sv =====
`default_nettype none

module bgd_core #(
   parameter int TIME_BITS = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 step,
   input  bgd_pkg::sample_type sample,
   input  bgd_pkg::cfg_type    cfg,
   output bgd_pkg::result_type result
);
   import bgd_pkg::*;

   logic                 was_held_ff, was_held_in;
   logic                 last_switch_ff, last_switch_in;
   logic [TIME_BITS-1:0] press_stamp_ff, press_stamp_in;
   logic [TIME_BITS-1:0] release_stamp_ff, release_stamp_in;
   logic                 tap_pending_ff, tap_pending_in;
   logic                 knob_touched_ff, knob_touched_in;
   logic                 aux_active_ff, aux_active_in;
   logic                 shift_ff, shift_in;
   logic                 live_fill_ff, live_fill_in;

   logic [TIME_BITS-1:0] t;
   logic [TIME_BITS-1:0] since_press;
   logic [TIME_BITS-1:0] since_release;
   logic [TIME_BITS-1:0] held;
   logic                 press_start;
   logic                 release_edge;
   logic                 switch_move;

   assign t             = TIME_BITS'(sample.time_ms);
   assign since_press   = t - press_stamp_ff;
   assign since_release = t - release_stamp_ff;
   assign press_start   = sample.button_pressed && !was_held_ff;
   assign release_edge  = !sample.button_pressed && was_held_ff;
   assign switch_move   = sample.button_pressed && (sample.switch_up != last_switch_ff);
   // press stamp becomes t on the press sample, so the hold time is zero there
   assign held          = press_start ? '0 : since_press;

   always_comb begin
      was_held_in      = sample.button_pressed;
      last_switch_in   = sample.switch_up;
      press_stamp_in   = press_stamp_ff;
      release_stamp_in = release_stamp_ff;
      tap_pending_in   = tap_pending_ff;
      knob_touched_in  = knob_touched_ff;
      aux_active_in    = aux_active_ff;
      shift_in         = shift_ff;
      live_fill_in     = live_fill_ff;
      result           = '0;
      result.aux_request = AUX_NONE;

      if (switch_move) begin
         aux_active_in          = 1'b1;
         live_fill_in           = 1'b0;
         result.switch_consumed = 1'b1;
         result.aux_request     = sample.switch_up ? AUX_HAT : AUX_FILL_GATE;
      end

      if (sample.button_pressed && sample.knob_moved) begin
         knob_touched_in = 1'b1;
      end

      if (press_start) begin
         press_stamp_in  = t;
         knob_touched_in = 1'b0;
         live_fill_in    = 1'b0;
         aux_active_in   = 1'b0;
      end

      if (sample.button_pressed && !aux_active_in) begin
         shift_in = held >= TIME_BITS'(cfg.hold_threshold_ms);
         if (held >= TIME_BITS'(cfg.live_fill_threshold_ms) && !knob_touched_in) begin
            live_fill_in = 1'b1;
         end
      end

      if (release_edge) begin
         release_stamp_in = t;
         shift_in         = 1'b0;
         live_fill_in     = 1'b0;
         if (aux_active_ff) begin
            aux_active_in  = 1'b0;
            tap_pending_in = 1'b0;
         end else if (since_press < TIME_BITS'(cfg.tap_max_ms)) begin
            // gap is taken from the previous release
            if (tap_pending_ff && since_release < TIME_BITS'(cfg.double_tap_window_ms)) begin
               result.double_tap = 1'b1;
               tap_pending_in    = 1'b0;
            end else begin
               result.tap     = 1'b1;
               tap_pending_in = 1'b1;
            end
         end else begin
            tap_pending_in = 1'b0;
         end
      end else if (!sample.button_pressed && tap_pending_ff) begin
         // the release sample takes the branch above, so expiry is only checked on later samples
         if (since_release > TIME_BITS'(cfg.double_tap_window_ms)) begin
            tap_pending_in = 1'b0;
         end
      end

      result.shift_on     = shift_in;
      result.live_fill_on = live_fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         was_held_ff      <= 1'b0;
         last_switch_ff   <= 1'b1;
         press_stamp_ff   <= '0;
         release_stamp_ff <= '0;
         tap_pending_ff   <= 1'b0;
         knob_touched_ff  <= 1'b0;
         aux_active_ff    <= 1'b0;
         shift_ff         <= 1'b0;
         live_fill_ff     <= 1'b0;
      end else if (step) begin
         was_held_ff      <= was_held_in;
         last_switch_ff   <= last_switch_in;
         press_stamp_ff   <= press_stamp_in;
         release_stamp_ff <= release_stamp_in;
         tap_pending_ff   <= tap_pending_in;
         knob_touched_ff  <= knob_touched_in;
         aux_active_ff    <= aux_active_in;
         shift_ff         <= shift_in;
         live_fill_ff     <= live_fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/button_gesture_detector.sv =====
`default_nettype none

// Button gesture detector: takes one sample beat per clock (button level,
// switch level, millisecond timestamp, knob flag) and returns one result beat
// per sample with tap / double-tap events, the shift and live-fill flags and
// any aux request from moving the switch while held. A sample lands in an
// input register, is evaluated against the gesture state in a single pass and
// its result is held in an output register; the sustained rate is one sample
// per cycle while rsp_stall is low. Timestamps are kept TIME_BITS wide and all
// time differences wrap at that width. The user must write threshold registers
// through the csr port only while no sample is in flight; the block does not
// enforce it. csr_ready is always high and unknown indexes are ignored.

module button_gesture_detector #(
   parameter int TIME_BITS = 32
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  wire                                    req_button_pressed,
   input  wire                                    req_switch_up,
   input  wire  [bgd_pkg::STAMP_IN_BITS-1:0]      req_time_ms,
   input  wire                                    req_knob_moved,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output logic                                   rsp_tap,
   output logic                                   rsp_double_tap,
   output logic                                   rsp_shift_on,
   output logic                                   rsp_live_fill_on,
   output logic                                   rsp_switch_consumed,
   output logic [1:0]                             rsp_aux_request,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [bgd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire  [bgd_pkg::THRESH_BITS-1:0]        csr_data
);
   import bgd_pkg::*;

   cfg_type    cfg_ff;
   sample_type in_sample_ff;
   logic       in_valid_ff;
   result_type rsp_result_ff;
   logic       rsp_valid_ff;
   result_type core_result;
   logic       out_free;
   logic       advance;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   bgd_core #(
      .TIME_BITS(TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .sample (in_sample_ff),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold_ms      <= 16'd500;
         cfg_ff.live_fill_threshold_ms <= 16'd1000;
         cfg_ff.tap_max_ms             <= 16'd200;
         cfg_ff.double_tap_window_ms   <= 16'd300;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HOLD_THRESHOLD:      cfg_ff.hold_threshold_ms      <= csr_data;
            CSR_LIVE_FILL_THRESHOLD: cfg_ff.live_fill_threshold_ms <= csr_data;
            CSR_TAP_MAX:             cfg_ff.tap_max_ms             <= csr_data;
            CSR_DOUBLE_TAP_WINDOW:   cfg_ff.double_tap_window_ms   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_sample_ff.button_pressed <= req_button_pressed;
         in_sample_ff.switch_up      <= req_switch_up;
         in_sample_ff.time_ms        <= req_time_ms;
         in_sample_ff.knob_moved     <= req_knob_moved;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= core_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tap             = rsp_result_ff.tap;
   assign rsp_double_tap      = rsp_result_ff.double_tap;
   assign rsp_shift_on        = rsp_result_ff.shift_on;
   assign rsp_live_fill_on    = rsp_result_ff.live_fill_on;
   assign rsp_switch_consumed = rsp_result_ff.switch_consumed;
   assign rsp_aux_request     = rsp_result_ff.aux_request;

endmodule

`default_nettype wire
